FILE: rtl/tpag_pkg.sv
package tpag_pkg;

	localparam int IDX_BITS        = 32;
	localparam int DIV_STEP        = 4;
	localparam int AXIS_FIELD_BITS = 2;
	localparam int MAP_AXES        = 4;
	localparam int CFG_INDEX_BITS  = 3;
	localparam int CFG_DATA_BITS   = 64;
	localparam int RANK_REG_BITS   = 3;
	localparam int MAP_REG_BITS    = 8;
	localparam int ELEM_BITS       = 4;

	localparam logic [RANK_REG_BITS-1:0] RANK_RESET   = 3'd1;
	localparam logic [CFG_DATA_BITS-1:0] DIMS_RESET   = 64'd1;
	localparam logic [MAP_REG_BITS-1:0]  MAP_RESET    = 8'd228;
	localparam logic [CFG_DATA_BITS-1:0] STRIDE_RESET = 64'd0;
	localparam logic [ELEM_BITS-1:0]     ELEM_RESET   = 4'd4;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_BAD_MAP  = 2'd1,
		ST_ZERO_DIM = 2'd2,
		ST_OVERFLOW = 2'd3
	} status_t;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		CFG_RANK       = 3'd0,
		CFG_DIMS       = 3'd1,
		CFG_AXIS_MAP   = 3'd2,
		CFG_STRIDE_01  = 3'd3,
		CFG_STRIDE_23  = 3'd4,
		CFG_ELEM_BYTES = 3'd5
	} cfg_reg_t;

endpackage

FILE: rtl/tpag_cfg.sv
module tpag_cfg import tpag_pkg::*; #(
	parameter int MAX_RANK    = 4,
	parameter int DIM_BITS    = 16,
	parameter int STRIDE_BITS = 32
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 wr_en,
	input  logic [CFG_INDEX_BITS-1:0]            wr_index,
	input  logic [CFG_DATA_BITS-1:0]             wr_data,
	output logic [MAX_RANK-1:0][DIM_BITS-1:0]    div_dim,
	output logic [MAX_RANK-1:0][STRIDE_BITS-1:0] axis_stride,
	output logic [ELEM_BITS-1:0]                 elem_bytes,
	output status_t                              cfg_status
);

	localparam int NAX    = (MAX_RANK > MAP_AXES) ? MAX_RANK : MAP_AXES;
	localparam int MAP_W  = AXIS_FIELD_BITS * NAX;
	localparam int DIMS_W = (DIM_BITS * NAX > CFG_DATA_BITS) ? DIM_BITS * NAX : CFG_DATA_BITS;
	localparam int RANK_W = $clog2(MAX_RANK + 1);

	logic [RANK_REG_BITS-1:0] rank_q;
	logic [CFG_DATA_BITS-1:0] dims_q;
	logic [MAP_REG_BITS-1:0]  map_q;
	logic [CFG_DATA_BITS-1:0] stride01_q;
	logic [CFG_DATA_BITS-1:0] stride23_q;
	logic [ELEM_BITS-1:0]     elem_q;

	logic [RANK_W-1:0]                          rank_eff;
	logic [MAP_W-1:0]                           map_ext;
	logic [DIMS_W-1:0]                          dims_ext;
	logic [NAX-1:0][DIM_BITS-1:0]               dim_in;
	logic [MAP_AXES-1:0][STRIDE_BITS-1:0]       stride_in;
	logic [MAX_RANK-1:0][AXIS_FIELD_BITS-1:0]   fld;
	logic [NAX-1:0]                             seen;
	logic                                       bad_map;
	logic                                       zero_dim;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rank_q     <= RANK_RESET;
			dims_q     <= DIMS_RESET;
			map_q      <= MAP_RESET;
			stride01_q <= STRIDE_RESET;
			stride23_q <= STRIDE_RESET;
			elem_q     <= ELEM_RESET;
		end else if (wr_en) begin
			unique case (cfg_reg_t'(wr_index))
				CFG_RANK:       rank_q     <= wr_data[RANK_REG_BITS-1:0];
				CFG_DIMS:       dims_q     <= wr_data;
				CFG_AXIS_MAP:   map_q      <= wr_data[MAP_REG_BITS-1:0];
				CFG_STRIDE_01:  stride01_q <= wr_data;
				CFG_STRIDE_23:  stride23_q <= wr_data;
				CFG_ELEM_BYTES: elem_q     <= wr_data[ELEM_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (rank_q == '0) begin
			rank_eff = RANK_W'(1);
		end else if (int'(rank_q) > MAX_RANK) begin
			rank_eff = RANK_W'(MAX_RANK);
		end else begin
			rank_eff = RANK_W'(rank_q);
		end

		map_ext  = MAP_W'(map_q);
		dims_ext = DIMS_W'(dims_q);
		for (int a = 0; a < NAX; a++) begin
			dim_in[a] = dims_ext[a*DIM_BITS +: DIM_BITS];
		end
		stride_in[0] = STRIDE_BITS'(stride01_q);
		stride_in[1] = STRIDE_BITS'(stride01_q >> STRIDE_BITS);
		stride_in[2] = STRIDE_BITS'(stride23_q);
		stride_in[3] = STRIDE_BITS'(stride23_q >> STRIDE_BITS);

		seen     = '0;
		bad_map  = 1'b0;
		zero_dim = 1'b0;
		for (int k = 0; k < MAX_RANK; k++) begin
			fld[k] = map_ext[k*AXIS_FIELD_BITS +: AXIS_FIELD_BITS];
			if (k < int'(rank_eff)) begin
				if (int'(fld[k]) >= int'(rank_eff) || seen[fld[k]]) begin
					bad_map = 1'b1;
				end
				seen[fld[k]] = 1'b1;
				if (dim_in[k] == '0) begin
					zero_dim = 1'b1;
				end
				div_dim[k]     = dim_in[fld[k]];
				axis_stride[k] = stride_in[fld[k]];
			end else begin
				// An unused output axis divides by one, so the running index passes unchanged.
				div_dim[k]     = DIM_BITS'(1);
				axis_stride[k] = '0;
			end
		end

		if (bad_map) begin
			cfg_status = ST_BAD_MAP;
		end else if (zero_dim) begin
			cfg_status = ST_ZERO_DIM;
		end else begin
			cfg_status = ST_OK;
		end
	end

	assign elem_bytes = elem_q;

endmodule

FILE: rtl/tpag_divider.sv
module tpag_divider import tpag_pkg::*; #(
	parameter int DIM_BITS = 16,
	parameter int SIDE_W   = 96
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic [IDX_BITS-1:0] in_dividend,
	input  logic [SIDE_W-1:0]   in_side,
	input  logic [DIM_BITS-1:0] divisor,
	output logic                out_valid,
	output logic [IDX_BITS-1:0] out_quotient,
	output logic [DIM_BITS-1:0] out_remainder,
	output logic [SIDE_W-1:0]   out_side
);

	localparam int NST = IDX_BITS / DIV_STEP;

	logic                vld_s  [NST];
	logic [IDX_BITS-1:0] work_s [NST];
	logic [DIM_BITS-1:0] rem_s  [NST];
	logic [SIDE_W-1:0]   side_s [NST];

	for (genvar st = 0; st < NST; st++) begin : g_stage
		logic                prev_vld;
		logic [IDX_BITS-1:0] prev_work;
		logic [IDX_BITS-1:0] nxt_work;
		logic [DIM_BITS-1:0] prev_rem;
		logic [DIM_BITS-1:0] nxt_rem;
		logic [SIDE_W-1:0]   prev_side;
		logic [DIM_BITS:0]   trial;

		if (st == 0) begin : g_first
			assign prev_vld  = in_valid;
			assign prev_work = in_dividend;
			assign prev_rem  = '0;
			assign prev_side = in_side;
		end else begin : g_next
			assign prev_vld  = vld_s[st-1];
			assign prev_work = work_s[st-1];
			assign prev_rem  = rem_s[st-1];
			assign prev_side = side_s[st-1];
		end

		// Dividend bits leave at the top of the work word while quotient bits enter at the bottom.
		always_comb begin
			nxt_work = prev_work;
			nxt_rem  = prev_rem;
			trial    = '0;
			for (int i = 0; i < DIV_STEP; i++) begin
				trial    = {nxt_rem, nxt_work[IDX_BITS-1]};
				nxt_work = {nxt_work[IDX_BITS-2:0], 1'b0};
				if (trial >= {1'b0, divisor}) begin
					nxt_rem     = DIM_BITS'(trial - {1'b0, divisor});
					nxt_work[0] = 1'b1;
				end else begin
					nxt_rem = DIM_BITS'(trial);
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[st] <= 1'b0;
			end else begin
				vld_s[st] <= prev_vld;
			end
		end

		always_ff @(posedge clk) begin
			work_s[st] <= nxt_work;
			rem_s[st]  <= nxt_rem;
			side_s[st] <= prev_side;
		end
	end

	assign out_valid     = vld_s[NST-1];
	assign out_quotient  = work_s[NST-1];
	assign out_remainder = rem_s[NST-1];
	assign out_side      = side_s[NST-1];

	a_div_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid |-> ##NST out_valid)
		else $error("divider lost an item");

endmodule

FILE: rtl/tpag_offset.sv
module tpag_offset import tpag_pkg::*; #(
	parameter int MAX_RANK    = 4,
	parameter int DIM_BITS    = 16,
	parameter int STRIDE_BITS = 32,
	parameter int OFFSET_BITS = 40
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	input  logic [IDX_BITS-1:0]                  in_flat,
	input  logic [MAX_RANK-1:0][DIM_BITS-1:0]    in_coord,
	input  logic [MAX_RANK-1:0][STRIDE_BITS-1:0] axis_stride,
	input  logic [ELEM_BITS-1:0]                 elem_bytes,
	input  status_t                              cfg_status,
	output logic                                 done,
	output logic [OFFSET_BITS-1:0]               source_offset,
	output logic [OFFSET_BITS-1:0]               dest_offset,
	output status_t                              status
);

	localparam int PW     = DIM_BITS + STRIDE_BITS;
	localparam int SUM_W  = PW + $clog2(MAX_RANK) + 1;
	localparam int DEST_W = IDX_BITS + ELEM_BITS;

	logic                         vld_s1;
	logic [MAX_RANK-1:0][PW-1:0]  prod_s1;
	logic [DEST_W-1:0]            dest_s1;
	logic                         vld_s2;
	logic [SUM_W-1:0]             sum_s2;
	logic [DEST_W-1:0]            dest_s2;
	logic                         done_s3;
	logic [OFFSET_BITS-1:0]       src_s3;
	logic [OFFSET_BITS-1:0]       dst_s3;
	status_t                      status_s3;

	logic [SUM_W-1:0] sum_nxt;
	logic             ovf;

	always_comb begin
		sum_nxt = '0;
		for (int k = 0; k < MAX_RANK; k++) begin
			sum_nxt = sum_nxt + SUM_W'(prod_s1[k]);
		end
	end

	// The strided terms are never negative, so the running sum passes the limit only if the total does.
	assign ovf = (sum_s2 >> OFFSET_BITS) != SUM_W'(0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			done_s3 <= 1'b0;
		end else begin
			vld_s1  <= in_valid;
			vld_s2  <= vld_s1;
			done_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < MAX_RANK; k++) begin
			prod_s1[k] <= PW'(in_coord[k]) * PW'(axis_stride[k]);
		end
		dest_s1 <= DEST_W'(in_flat) * DEST_W'(elem_bytes);
		sum_s2  <= sum_nxt;
		dest_s2 <= dest_s1;
		if (cfg_status != ST_OK) begin
			status_s3 <= cfg_status;
			src_s3    <= '0;
			dst_s3    <= '0;
		end else if (ovf) begin
			status_s3 <= ST_OVERFLOW;
			src_s3    <= '0;
			dst_s3    <= '0;
		end else begin
			status_s3 <= ST_OK;
			src_s3    <= OFFSET_BITS'(sum_s2);
			dst_s3    <= OFFSET_BITS'(dest_s2);
		end
	end

	assign done          = done_s3;
	assign source_offset = src_s3;
	assign dest_offset   = dst_s3;
	assign status        = status_s3;

endmodule

FILE: rtl/tensor_permute_address_generator.sv
// Takes one flat output index per clock on start while busy is low and returns the strided
// source byte offset, the dense destination byte offset and a status; busy is high during
// reset and until the first clock edge after its release.
// Each item's result is strobed on done for one cycle, and the receiver cannot stall it.
// Each item passes through an input register, then a chain of restoring dividers, one per
// output axis, each retiring four quotient bits per stage, then the multiply, sum and overflow
// stages. Configuration is to be written by the user only while no item is in flight;
// the block itself does not enforce this.
module tensor_permute_address_generator import tpag_pkg::*; #(
	parameter int MAX_RANK    = 4,
	parameter int DIM_BITS    = 16,
	parameter int STRIDE_BITS = 32,
	parameter int OFFSET_BITS = 40
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [IDX_BITS-1:0]       elem_index,
	output logic                      done,
	output logic [OFFSET_BITS-1:0]    source_offset,
	output logic [OFFSET_BITS-1:0]    dest_offset,
	output logic [1:0]                status,
	input  logic                      wr_en,
	input  logic [CFG_INDEX_BITS-1:0] wr_index,
	input  logic [CFG_DATA_BITS-1:0]  wr_data
);

	localparam int NST     = IDX_BITS / DIV_STEP;
	localparam int COORD_W = MAX_RANK * DIM_BITS;
	localparam int SIDE_W  = IDX_BITS + COORD_W;
	localparam int LATENCY = MAX_RANK * NST + 4;

	logic                                 busy_q;
	logic                                 accept;
	logic                                 vld_s1;
	logic [IDX_BITS-1:0]                  flat_s1;
	logic [MAX_RANK-1:0][DIM_BITS-1:0]    div_dim;
	logic [MAX_RANK-1:0][STRIDE_BITS-1:0] axis_stride;
	logic [ELEM_BITS-1:0]                 elem_bytes;
	status_t                              cfg_status;
	status_t                              status_out;

	logic                chain_vld  [MAX_RANK+1];
	logic [IDX_BITS-1:0] chain_rest [MAX_RANK+1];
	logic [SIDE_W-1:0]   chain_side [MAX_RANK+1];

	logic [MAX_RANK-1:0][DIM_BITS-1:0] coords;
	logic [IDX_BITS-1:0]               flat_end;

	assign accept = start && !busy_q;
	assign busy   = busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			vld_s1 <= 1'b0;
		end else begin
			busy_q <= 1'b0;
			vld_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			flat_s1 <= elem_index;
		end
	end

	tpag_cfg #(
		.MAX_RANK    (MAX_RANK),
		.DIM_BITS    (DIM_BITS),
		.STRIDE_BITS (STRIDE_BITS)
	) u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.wr_en       (wr_en),
		.wr_index    (wr_index),
		.wr_data     (wr_data),
		.div_dim     (div_dim),
		.axis_stride (axis_stride),
		.elem_bytes  (elem_bytes),
		.cfg_status  (cfg_status)
	);

	assign chain_vld[0]  = vld_s1;
	assign chain_rest[0] = flat_s1;
	assign chain_side[0] = {flat_s1, COORD_W'(0)};

	// The last output axis varies fastest, so it is divided out first.
	for (genvar j = 0; j < MAX_RANK; j++) begin : g_axis
		localparam int K = MAX_RANK - 1 - j;

		logic [IDX_BITS-1:0] u_quot;
		logic [DIM_BITS-1:0] u_rem;
		logic [SIDE_W-1:0]   u_side;
		logic [SIDE_W-1:0]   side_ins;

		tpag_divider #(
			.DIM_BITS (DIM_BITS),
			.SIDE_W   (SIDE_W)
		) u_div (
			.clk           (clk),
			.arst_n        (arst_n),
			.in_valid      (chain_vld[j]),
			.in_dividend   (chain_rest[j]),
			.in_side       (chain_side[j]),
			.divisor       (div_dim[K]),
			.out_valid     (chain_vld[j+1]),
			.out_quotient  (u_quot),
			.out_remainder (u_rem),
			.out_side      (u_side)
		);

		always_comb begin
			side_ins = u_side;
			side_ins[K*DIM_BITS +: DIM_BITS] = u_rem;
		end

		assign chain_rest[j+1] = u_quot;
		assign chain_side[j+1] = side_ins;
	end

	assign coords   = chain_side[MAX_RANK][COORD_W-1:0];
	assign flat_end = chain_side[MAX_RANK][SIDE_W-1 -: IDX_BITS];

	tpag_offset #(
		.MAX_RANK    (MAX_RANK),
		.DIM_BITS    (DIM_BITS),
		.STRIDE_BITS (STRIDE_BITS),
		.OFFSET_BITS (OFFSET_BITS)
	) u_offset (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (chain_vld[MAX_RANK]),
		.in_flat       (flat_end),
		.in_coord      (coords),
		.axis_stride   (axis_stride),
		.elem_bytes    (elem_bytes),
		.cfg_status    (cfg_status),
		.done          (done),
		.source_offset (source_offset),
		.dest_offset   (dest_offset),
		.status        (status_out)
	);

	assign status = status_out;

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##LATENCY done)
		else $error("accepted item produced no result");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, LATENCY))
		else $error("result without a matching item");

	a_error_zeroes: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != ST_OK |-> source_offset == '0 && dest_offset == '0)
		else $error("offsets not cleared on error");

endmodule

FILE: tb/sv/perm_offset_checker.sv
module perm_offset_checker import tpag_pkg::*; #(
	parameter int DIM_BITS    = 16,
	parameter int STRIDE_BITS = 32,
	parameter int OFFSET_BITS = 40
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic                      busy,
	input  logic [IDX_BITS-1:0]       elem_index,
	input  logic                      done,
	input  logic [OFFSET_BITS-1:0]    source_offset,
	input  logic [OFFSET_BITS-1:0]    dest_offset,
	input  logic [1:0]                status,
	input  logic                      wr_en,
	input  logic [CFG_INDEX_BITS-1:0] wr_index,
	input  logic [CFG_DATA_BITS-1:0]  wr_data,
	output int                        fail_count,
	output int                        pending,
	output int                        checked,
	output int                        errors_seen
);

	localparam logic [63:0] OFFSET_LIMIT = (64'd1 << OFFSET_BITS) - 64'd1;
	localparam int MISMATCH_LINES = 40;

	typedef struct packed {
		logic [IDX_BITS-1:0]    idx;
		logic [OFFSET_BITS-1:0] src;
		logic [OFFSET_BITS-1:0] dst;
		status_t                st;
	} offsets_t;

	logic [RANK_REG_BITS-1:0] rank_reg;
	logic [CFG_DATA_BITS-1:0] dims_reg;
	logic [MAP_REG_BITS-1:0]  map_reg;
	logic [CFG_DATA_BITS-1:0] stride01_reg;
	logic [CFG_DATA_BITS-1:0] stride23_reg;
	logic [ELEM_BITS-1:0]     elem_reg;

	offsets_t expected_q[$];
	offsets_t head;
	int n_fail = 0;
	int n_checked = 0;
	int n_errors = 0;
	int n_pending = 0;

	assign fail_count  = n_fail;
	assign pending     = n_pending;
	assign checked     = n_checked;
	assign errors_seen = n_errors;

	task automatic report_mismatch(input string what);
		n_fail++;
		if (n_fail <= MISMATCH_LINES)
			$display("%0t mismatch: %s", $time, what);
	endtask

	function automatic logic [63:0] axis_stride(input int axis);
		logic [CFG_DATA_BITS-1:0] reg_val;
		reg_val = (axis < 2) ? stride01_reg : stride23_reg;
		return 64'(reg_val[(axis % 2) * STRIDE_BITS +: STRIDE_BITS]);
	endfunction

	function automatic offsets_t predict_offsets(input logic [IDX_BITS-1:0] idx);
		offsets_t    r;
		int          rank;
		int          axis_of[MAP_AXES];
		bit          named[MAP_AXES];
		logic [63:0] coord[MAP_AXES];
		logic [63:0] rest;
		logic [63:0] d;
		logic [63:0] c;
		logic [63:0] s;
		logic [63:0] src;
		int          a;
		status_t     st;
		rank = int'(rank_reg);
		if (rank < 1)
			rank = 1;
		if (rank > MAP_AXES)
			rank = MAP_AXES;
		for (int k = 0; k < MAP_AXES; k++) begin
			axis_of[k] = 0;
			named[k] = 1'b0;
			coord[k] = '0;
		end
		st = ST_OK;
		for (int k = 0; k < rank; k++) begin
			a = int'(map_reg[k * AXIS_FIELD_BITS +: AXIS_FIELD_BITS]);
			if (a >= rank || named[a]) begin
				st = ST_BAD_MAP;
				break;
			end
			named[a] = 1'b1;
			axis_of[k] = a;
		end
		if (st == ST_OK) begin
			for (int k = 0; k < rank; k++) begin
				if (dims_reg[k * DIM_BITS +: DIM_BITS] == '0) begin
					st = ST_ZERO_DIM;
					break;
				end
			end
		end
		src = '0;
		if (st == ST_OK) begin
			rest = 64'(idx);
			for (int k = rank - 1; k >= 0; k--) begin
				d = 64'(dims_reg[axis_of[k] * DIM_BITS +: DIM_BITS]);
				coord[axis_of[k]] = rest % d;
				rest = rest / d;
			end
			for (int k = 0; k < rank; k++) begin
				c = coord[k];
				s = axis_stride(k);
				if (c != 0 && s > (OFFSET_LIMIT - src) / c) begin
					st = ST_OVERFLOW;
					break;
				end
				src = src + c * s;
			end
		end
		r.idx = idx;
		r.st = st;
		if (st == ST_OK) begin
			r.src = OFFSET_BITS'(src & OFFSET_LIMIT);
			r.dst = OFFSET_BITS'((64'(idx) * 64'(elem_reg)) & OFFSET_LIMIT);
		end else begin
			r.src = '0;
			r.dst = '0;
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rank_reg <= RANK_RESET;
			dims_reg <= DIMS_RESET;
			map_reg <= MAP_RESET;
			stride01_reg <= STRIDE_RESET;
			stride23_reg <= STRIDE_RESET;
			elem_reg <= ELEM_RESET;
			expected_q.delete();
			n_pending = 0;
		end else begin
			if (start && !busy)
				expected_q.insert(expected_q.size(), predict_offsets(elem_index));
			if (done) begin
				if (expected_q.size() == 0) begin
					report_mismatch("result strobed with no item outstanding");
				end else begin
					head = expected_q.pop_front();
					n_checked++;
					if (head.st != ST_OK)
						n_errors++;
					if (status !== head.st)
						report_mismatch($sformatf("index %h: status %0d, expected %0d",
							head.idx, status, head.st));
					if (source_offset !== head.src)
						report_mismatch($sformatf("index %h: source_offset %h, expected %h",
							head.idx, source_offset, head.src));
					if (dest_offset !== head.dst)
						report_mismatch($sformatf("index %h: dest_offset %h, expected %h",
							head.idx, dest_offset, head.dst));
				end
			end
			if (wr_en) begin
				case (cfg_reg_t'(wr_index))
					CFG_RANK:       rank_reg <= wr_data[RANK_REG_BITS-1:0];
					CFG_DIMS:       dims_reg <= wr_data;
					CFG_AXIS_MAP:   map_reg <= wr_data[MAP_REG_BITS-1:0];
					CFG_STRIDE_01:  stride01_reg <= wr_data;
					CFG_STRIDE_23:  stride23_reg <= wr_data;
					CFG_ELEM_BYTES: elem_reg <= wr_data[ELEM_BITS-1:0];
					default: begin
					end
				endcase
			end
			n_pending = expected_q.size();
		end
	end

endmodule

FILE: tb/sv/tb_tensor_permute_address_generator.sv
module tb_tensor_permute_address_generator;
	import tpag_pkg::*;

	localparam int OFFSET_BITS = 40;
	localparam int ITEM_TARGET = 1450;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      start = 1'b0;
	logic [IDX_BITS-1:0]       elem_index = '0;
	logic                      wr_en = 1'b0;
	logic [CFG_INDEX_BITS-1:0] wr_index = '0;
	logic [CFG_DATA_BITS-1:0]  wr_data = '0;
	logic                      busy;
	logic                      done;
	logic [OFFSET_BITS-1:0]    source_offset;
	logic [OFFSET_BITS-1:0]    dest_offset;
	logic [1:0]                status;

	int fail_count;
	int pending;
	int checked;
	int errors_seen;
	int items_sent = 0;
	int setups_run = 0;
	logic [63:0] tensor_span = 64'd1;

	always #6 clk = ~clk;

	tensor_permute_address_generator uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.elem_index(elem_index),
		.done(done),
		.source_offset(source_offset),
		.dest_offset(dest_offset),
		.status(status),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data)
	);

	perm_offset_checker watch (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.elem_index(elem_index),
		.done(done),
		.source_offset(source_offset),
		.dest_offset(dest_offset),
		.status(status),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data),
		.fail_count(fail_count),
		.pending(pending),
		.checked(checked),
		.errors_seen(errors_seen)
	);

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_BITS-1:0] data);
		wr_en = 1'b1;
		wr_index = idx;
		wr_data = data;
		@(negedge clk);
		wr_en = 1'b0;
	endtask

	task automatic load_setup(input logic [2:0] rank, input logic [63:0] dims,
			input logic [7:0] map, input logic [63:0] s01, input logic [63:0] s23,
			input logic [3:0] elem);
		int eff;
		start = 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
		write_reg(CFG_RANK, 64'(rank));
		write_reg(CFG_DIMS, dims);
		write_reg(CFG_AXIS_MAP, 64'(map));
		write_reg(CFG_STRIDE_01, s01);
		write_reg(CFG_STRIDE_23, s23);
		write_reg(CFG_ELEM_BYTES, 64'(elem));
		eff = (rank == 0) ? 1 : (rank > 4) ? 4 : int'(rank);
		tensor_span = 64'd1;
		for (int k = 0; k < eff; k++)
			tensor_span = tensor_span * 64'(dims[16 * k +: 16]);
		setups_run++;
	endtask

	task automatic send_index(input logic [IDX_BITS-1:0] idx);
		start = 1'b1;
		elem_index = idx;
		do
			@(posedge clk);
		while (busy);
		@(negedge clk);
		items_sent++;
	endtask

	function automatic logic [IDX_BITS-1:0] pick_index();
		int sel;
		sel = $urandom_range(0, 9);
		if (tensor_span == 0 || sel == 0)
			return $urandom;
		if (sel == 1)
			return IDX_BITS'(tensor_span + 64'($urandom_range(0, 3)));
		if (sel == 2)
			return IDX_BITS'(tensor_span - 64'd1);
		return IDX_BITS'({$urandom, $urandom} % tensor_span);
	endfunction

	function automatic logic [31:0] pick_stride();
		case ($urandom_range(0, 2))
			0: return 32'($urandom_range(0, 4096));
			1: return 32'd1 << $urandom_range(0, 31);
			default: return $urandom;
		endcase
	endfunction

	task automatic random_setup();
		logic [2:0]  rank;
		logic [7:0]  map;
		logic [63:0] dims;
		logic [3:0]  elem;
		int          eff;
		int          perm[4];
		int          j;
		int          t;
		int          pick;
		pick = $urandom_range(0, 19);
		if (pick == 0)
			rank = 3'd0;
		else if (pick == 1)
			rank = 3'($urandom_range(5, 7));
		else
			rank = 3'($urandom_range(1, 4));
		eff = (rank == 0) ? 1 : (rank > 4) ? 4 : int'(rank);
		for (int k = 0; k < 4; k++)
			perm[k] = k;
		for (int k = eff - 1; k > 0; k--) begin
			j = $urandom_range(0, k);
			t = perm[k];
			perm[k] = perm[j];
			perm[j] = t;
		end
		map = 8'($urandom);
		for (int k = 0; k < eff; k++)
			map[2 * k +: 2] = 2'(perm[k]);
		if ($urandom_range(0, 7) == 0)
			map = 8'($urandom);
		dims = {$urandom, $urandom};
		if ($urandom_range(0, 7) != 0) begin
			for (int k = 0; k < 4; k++)
				dims[16 * k +: 16] = ($urandom_range(0, 9) == 0) ?
					16'($urandom_range(1, 65535)) : 16'($urandom_range(1, 6));
			if ($urandom_range(0, 19) == 0) begin
				j = $urandom_range(0, 3);
				dims[16 * j +: 16] = 16'd0;
			end
		end
		elem = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'(1 << $urandom_range(0, 3));
		load_setup(rank, dims, map, {pick_stride(), pick_stride()},
			{pick_stride(), pick_stride()}, elem);
	endtask

	task automatic run_items(input int count);
		bit steady;
		int burst;
		int n;
		steady = ($urandom_range(0, 3) == 0);
		n = 0;
		while (n < count) begin
			burst = $urandom_range(1, 16);
			for (int j = 0; j < burst && n < count; j++) begin
				send_index(pick_index());
				n++;
			end
			if (!steady) begin
				start = 1'b0;
				repeat ($urandom_range(1, 7)) @(negedge clk);
			end
			if ($urandom_range(0, 30) == 0) begin
				start = 1'b0;
				while (pending != 0)
					@(negedge clk);
			end
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_index(32'h0000_0000);
		send_index(32'hFFFF_FFFF);
		send_index(32'h0000_0007);

		load_setup(3'd4, 64'h0005_0004_0003_0002, 8'h87, {32'd24, 32'd1000},
			{32'd7, 32'd96}, 4'd8);
		send_index(32'd0);
		send_index(32'd1);
		send_index(32'd119);
		send_index(32'd120);
		send_index(32'hFFFF_FFFF);

		load_setup(3'd3, 64'h0005_0004_0003_0002, 8'h14, {32'd24, 32'd1000},
			{32'd7, 32'd96}, 4'd8);
		send_index(32'd5);
		load_setup(3'd2, 64'h0005_0004_0003_0002, 8'h06, {32'd24, 32'd1000},
			{32'd7, 32'd96}, 4'd8);
		send_index(32'd3);

		load_setup(3'd2, 64'h0000_0000_0000_0007, 8'hE4, {32'd3, 32'd5}, 64'd0, 4'd2);
		send_index(32'd2);
		load_setup(3'd1, 64'h0000_0000_0000_0009, 8'hE4, {32'd3, 32'd5}, 64'd0, 4'd2);
		send_index(32'd4);
		send_index(32'd13);

		// Axis 0 stride times 25575 lands exactly on the largest 40-bit offset.
		load_setup(3'd2, 64'h0000_0000_0002_FFFF, 8'hE4, {32'd1, 32'd42991657},
			64'hFFFF_FFFF_FFFF_FFFF, 4'd15);
		send_index(32'd51150);
		send_index(32'd51151);
		send_index(32'hFFFF_FFFF);

		load_setup(3'd0, 64'hFFFF_FFFF_FFFF_0003, 8'hFC, {32'd9, 32'd5}, 64'd0, 4'd0);
		send_index(32'd2);
		send_index(32'd4);

		load_setup(3'd7, 64'h0002_0002_0002_0002, 8'h1B, 64'hFFFF_FFFF_FFFF_FFFF,
			64'hFFFF_FFFF_FFFF_FFFF, 4'd1);
		send_index(32'd15);
		send_index(32'd5);

		while (items_sent < ITEM_TARGET) begin
			if (setups_run % 9 == 4)
				load_setup(3'd4, 64'hFFFF_FFFF_FFFF_FFFF, 8'hE4, 64'hFFFF_FFFF_FFFF_FFFF,
					64'hFFFF_FFFF_FFFF_FFFF, 4'd15);
			else
				random_setup();
			run_items($urandom_range(20, 70));
		end

		start = 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (50) @(negedge clk);

		$display("Sent %0d items across %0d register setups; %0d results checked.",
			items_sent, setups_run, checked);
		$display("%0d results carried an error status (bad map, zero size or overflow).",
			errors_seen);
		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		#(12 * 400000);
		$display("Timed out with %0d results outstanding.", pending);
		$display("== FAIL ==");
		$finish;
	end

endmodule
